@@ rtl/core/sprite_screen_projection_assert.svh @@
// Assertion helpers for the RTL files of the sprite projection block.
`ifndef SPRITE_SCREEN_PROJECTION_ASSERT_SVH
`define SPRITE_SCREEN_PROJECTION_ASSERT_SVH

// Generic form with an explicit clock and active-low reset.
`define SSP_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Short form for modules clocked by clk_i and reset by rst_ni.
`define SSP_ASSERT(label, prop, msg) \
  `SSP_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

@@ rtl/core/ssp_pkg.sv @@
package ssp_pkg;

  localparam int unsigned SCREEN_W_DEF    = 640;
  localparam int unsigned SCREEN_H_DEF    = 480;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_PLAYER_X = 3'd0,
    CFG_PLAYER_Y = 3'd1,
    CFG_DIR_X    = 3'd2,
    CFG_DIR_Y    = 3'd3,
    CFG_PLANE_X  = 3'd4,
    CFG_PLANE_Y  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [23:0] player_x;
    logic signed [23:0] player_y;
    logic signed [17:0] dir_x;
    logic signed [17:0] dir_y;
    logic signed [17:0] plane_x;
    logic signed [17:0] plane_y;
  } cam_t;

  // One visible sprite handed from the classifier to the divider pipeline.
  typedef struct packed {
    logic [7:0]         id;
    logic [7:0]         tex;
    logic [43:0]        tyn_mag;
    logic [36:0]        det_mag;
    logic signed [44:0] s;
    logic               tyn_neg;
  } sprite_job_t;

  typedef struct packed {
    logic [7:0]         sprite_id;
    logic [7:0]         texture;
    logic signed [13:0] screen_column;
    logic [12:0]        sprite_size;
    logic [12:0]        start_column;
    logic signed [13:0] end_column;
    logic [7:0]         start_row;
    logic [8:0]         end_row;
    logic [22:0]        depth;
  } result_t;

endpackage

@@ rtl/core/ssp_front.sv @@
module ssp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ssp_pkg::cam_t       cam_i,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [7:0]          id_i,
  input  logic signed [23:0]  x_i,
  input  logic signed [23:0]  y_i,
  input  logic [7:0]          tex_i,
  output logic                push_o,
  input  logic                queue_ready_i,
  output ssp_pkg::sprite_job_t job_o
);

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  logic [7:0]         id1_q, tex1_q, id2_q, tex2_q, id3_q, tex3_q;
  logic signed [24:0] rx_q, ry_q;
  logic signed [42:0] pdx_q, pdy_q, ptx_a_q, ptx_b_q, pty_a_q, pty_b_q;
  logic signed [35:0] pdet_a_q, pdet_b_q;
  logic signed [43:0] dot_q, tyn_q;
  logic signed [36:0] det_q;
  logic signed [44:0] s_q;

  logic [36:0] det_mag;
  logic [43:0] tyn_mag;
  logic        keep;

  always_comb begin
    det_mag = det_q[36] ? 37'(-det_q) : 37'(det_q);
    tyn_mag = tyn_q[43] ? 44'(-tyn_q) : 44'(tyn_q);
    // A quotient of zero in the depth division is known from one compare.
    keep = !dot_q[43] && (det_q != '0) && (tyn_q != '0) && (tyn_q[43] == det_q[36]) &&
           ({tyn_mag, 16'b0} >= {23'b0, det_mag});
  end

  assign rdy3    = !v3_q || !keep || queue_ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;
  assign push_o  = v3_q && keep && queue_ready_i;

  always_comb begin
    job_o.id      = id3_q;
    job_o.tex     = tex3_q;
    job_o.tyn_mag = tyn_mag;
    job_o.det_mag = det_mag;
    job_o.s       = s_q;
    job_o.tyn_neg = tyn_q[43];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      id1_q  <= id_i;
      tex1_q <= tex_i;
      rx_q   <= $signed({x_i[23], x_i}) - $signed({cam_i.player_x[23], cam_i.player_x});
      ry_q   <= $signed({y_i[23], y_i}) - $signed({cam_i.player_y[23], cam_i.player_y});
    end
    if (rdy2) begin
      id2_q    <= id1_q;
      tex2_q   <= tex1_q;
      pdx_q    <= rx_q * cam_i.dir_x;
      pdy_q    <= ry_q * cam_i.dir_y;
      ptx_a_q  <= rx_q * cam_i.dir_y;
      ptx_b_q  <= ry_q * cam_i.dir_x;
      pty_a_q  <= ry_q * cam_i.plane_x;
      pty_b_q  <= rx_q * cam_i.plane_y;
      pdet_a_q <= cam_i.plane_x * cam_i.dir_y;
      pdet_b_q <= cam_i.dir_x * cam_i.plane_y;
    end
    if (rdy3) begin
      id3_q  <= id2_q;
      tex3_q <= tex2_q;
      dot_q  <= pdx_q + pdy_q;
      tyn_q  <= pty_a_q - pty_b_q;
      det_q  <= pdet_a_q - pdet_b_q;
      s_q    <= pty_a_q - pty_b_q + ptx_a_q - ptx_b_q;
    end
  end

endmodule

@@ rtl/core/ssp_fifo.sv @@
`include "sprite_screen_projection_assert.svh"

module ssp_fifo #(
  parameter int unsigned DEPTH = ssp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ssp_pkg::sprite_job_t data_i,
  output logic                 ready_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output ssp_pkg::sprite_job_t data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ssp_pkg::sprite_job_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] count_q;

  assign ready_o = count_q != CNT_W'(DEPTH);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      if (pop_i)  rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      if (push_i && !pop_i)      count_q <= count_q + CNT_W'(1);
      else if (pop_i && !push_i) count_q <= count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  `SSP_ASSERT(a_no_push_full, push_i |-> count_q != CNT_W'(DEPTH), "queue written while full")
  `SSP_ASSERT(a_no_pop_empty, pop_i |-> count_q != '0, "queue read while empty")
  `SSP_ASSERT(a_count_up, (push_i && !pop_i) |=> count_q == $past(count_q) + CNT_W'(1), "queue count lost a word")

endmodule

@@ rtl/core/ssp_back.sv @@
module ssp_back #(
  parameter int unsigned SCREEN_W = ssp_pkg::SCREEN_W_DEF,
  parameter int unsigned SCREEN_H = ssp_pkg::SCREEN_H_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  input  ssp_pkg::sprite_job_t job_i,
  output logic                 pop_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output ssp_pkg::result_t     result_o
);

  localparam int unsigned WW        = $clog2(SCREEN_W + 1);
  localparam int unsigned HW        = $clog2(SCREEN_H + 1);
  localparam int unsigned NC_W      = 45 + WW;
  localparam int unsigned NS_W      = 37 + HW;
  localparam int unsigned DIV_STEPS = 23;
  localparam int unsigned COL_STEPS = 13;
  localparam logic signed [15:0] HALF_H = 16'(SCREEN_H / 2);
  localparam logic signed [15:0] H_M1   = 16'(SCREEN_H - 1);
  localparam logic signed [15:0] W_M1   = 16'(SCREEN_W - 1);

  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  tex;
    logic        neg;
    logic        satd;
    logic        satc;
    logic        sats;
    logic [36:0] dd;
    logic [36:0] rd;
    logic [22:0] nd;
    logic [22:0] qd;
    logic [44:0] dc;
    logic [44:0] rc;
    logic [12:0] lc;
    logic [12:0] qc;
    logic [43:0] ds;
    logic [43:0] rs;
    logic [12:0] ls;
    logic [12:0] qs;
  } div_t;

  logic en;
  logic b1_v_q;
  logic [7:0]      b1_id_q, b1_tex_q;
  logic            b1_neg_q;
  logic [43:0]     b1_tyn_q;
  logic [36:0]     b1_det_q;
  logic [NC_W-1:0] b1_ncol_q;
  logic [NS_W-1:0] b1_nsz_q;
  logic [44:0]     s_mag;

  div_t st_q  [DIV_STEPS+1];
  logic vld_q [DIV_STEPS+1];
  div_t st0_d;

  ssp_pkg::result_t res_d, res_q;
  logic             out_v_q;

  // The whole back pipeline moves while the output register is free or taken.
  assign en      = !out_v_q || ready_i;
  assign pop_o   = en && job_valid_i;
  assign valid_o = out_v_q;
  assign result_o = res_q;

  assign s_mag = job_i.s[44] ? 45'(-job_i.s) : 45'(job_i.s);

  always_comb begin
    st0_d     = '0;
    st0_d.id  = b1_id_q;
    st0_d.tex = b1_tex_q;
    st0_d.neg = b1_neg_q;
    st0_d.dd  = b1_det_q;
    st0_d.rd  = b1_tyn_q[43:7];
    st0_d.nd  = {b1_tyn_q[6:0], 16'b0};
    st0_d.satd = b1_tyn_q >= {b1_det_q, 7'b0};
    st0_d.dc  = {b1_tyn_q, 1'b0};
    st0_d.rc  = 45'(b1_ncol_q >> 13);
    st0_d.lc  = b1_ncol_q[12:0];
    st0_d.satc = 64'(b1_ncol_q) >= 64'({b1_tyn_q, 14'b0});
    st0_d.ds  = b1_tyn_q;
    st0_d.rs  = 44'(b1_nsz_q >> 13);
    st0_d.ls  = b1_nsz_q[12:0];
    st0_d.sats = 64'(b1_nsz_q) >= 64'({b1_tyn_q, 13'b0});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q   <= 1'b0;
      vld_q[0] <= 1'b0;
    end else if (en) begin
      b1_v_q   <= job_valid_i;
      vld_q[0] <= b1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_id_q   <= job_i.id;
      b1_tex_q  <= job_i.tex;
      b1_neg_q  <= job_i.s[44] ^ job_i.tyn_neg;
      b1_tyn_q  <= job_i.tyn_mag;
      b1_det_q  <= job_i.det_mag;
      b1_ncol_q <= NC_W'(s_mag) * NC_W'(SCREEN_W);
      b1_nsz_q  <= NS_W'(job_i.det_mag) * NS_W'(SCREEN_H);
      st_q[0]   <= st0_d;
    end
  end

  // One restoring step of each division per stage; column and size finish early.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    div_t        nx;
    logic [37:0] td;
    logic [45:0] tc;
    logic [44:0] ts;

    always_comb begin
      nx = st_q[k];
      td = {st_q[k].rd, st_q[k].nd[22]};
      tc = {st_q[k].rc, st_q[k].lc[12]};
      ts = {st_q[k].rs, st_q[k].ls[12]};
      nx.nd = {st_q[k].nd[21:0], 1'b0};
      if (td >= {1'b0, st_q[k].dd}) begin
        nx.rd = 37'(td - {1'b0, st_q[k].dd});
        nx.qd = {st_q[k].qd[21:0], 1'b1};
      end else begin
        nx.rd = td[36:0];
        nx.qd = {st_q[k].qd[21:0], 1'b0};
      end
      if (k < COL_STEPS) begin
        nx.lc = {st_q[k].lc[11:0], 1'b0};
        nx.ls = {st_q[k].ls[11:0], 1'b0};
        if (tc >= {1'b0, st_q[k].dc}) begin
          nx.rc = 45'(tc - {1'b0, st_q[k].dc});
          nx.qc = {st_q[k].qc[11:0], 1'b1};
        end else begin
          nx.rc = tc[44:0];
          nx.qc = {st_q[k].qc[11:0], 1'b0};
        end
        if (ts >= {1'b0, st_q[k].ds}) begin
          nx.rs = 44'(ts - {1'b0, st_q[k].ds});
          nx.qs = {st_q[k].qs[11:0], 1'b1};
        end else begin
          nx.rs = ts[43:0];
          nx.qs = {st_q[k].qs[11:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) st_q[k+1] <= nx;
    end
  end

  logic signed [13:0] col;
  logic [12:0]        size;
  logic signed [15:0] colw, halfw, scolw, ecolw, sroww, eroww;

  always_comb begin
    if (st_q[DIV_STEPS].satc) begin
      col = st_q[DIV_STEPS].neg ? 14'sh2000 : 14'sh1FFF;
    end else if (st_q[DIV_STEPS].neg) begin
      col = -$signed({1'b0, st_q[DIV_STEPS].qc});
    end else begin
      col = $signed({1'b0, st_q[DIV_STEPS].qc});
    end
    size  = st_q[DIV_STEPS].sats ? 13'h1FFF : st_q[DIV_STEPS].qs;
    colw  = {{2{col[13]}}, col};
    halfw = {4'b0, size[12:1]};
    scolw = colw - halfw;
    ecolw = colw + halfw;
    sroww = HALF_H - halfw;
    eroww = HALF_H + halfw;

    res_d.sprite_id     = st_q[DIV_STEPS].id;
    res_d.texture       = st_q[DIV_STEPS].tex;
    res_d.screen_column = col;
    res_d.sprite_size   = size;
    res_d.start_column  = scolw[15] ? '0 : scolw[12:0];
    res_d.end_column    = (ecolw > W_M1) ? W_M1[13:0] : ecolw[13:0];
    res_d.start_row     = sroww[15] ? '0 : sroww[7:0];
    res_d.end_row       = (eroww > H_M1) ? H_M1[8:0] : eroww[8:0];
    res_d.depth         = st_q[DIV_STEPS].satd ? 23'h7FFFFF : st_q[DIV_STEPS].qd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= vld_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) res_q <= res_d;
  end

endmodule

@@ rtl/core/sprite_screen_projection.sv @@
// Channel     | Direction | Word
// s_axis      | in        | tdata: sprite_id, sprite_x, sprite_y, texture_index
// m_axis      | out       | tdata: visible sprite geometry and depth
// cfg         | in        | register index and value, always ready
//
// One sprite is taken every cycle unless a full queue stalls the front end. The word
// passes 30 registers: the three-stage transform front end, one in the queue, two set-up
// stages, the 23-stage restoring divider of the depth quotient and the output register.
// Reset clears all valid flags and loads the default camera; no clearing pass.
// A stalled output holds the back pipeline while a four-word queue lets the front
// end keep accepting sprites; hidden sprites never enter the queue.
module sprite_screen_projection #(
  parameter int unsigned SCREEN_W    = ssp_pkg::SCREEN_W_DEF,
  parameter int unsigned SCREEN_H    = ssp_pkg::SCREEN_H_DEF,
  parameter int unsigned QUEUE_DEPTH = ssp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // sprite_id[7:0], sprite_x[31:8], sprite_y[55:32], texture_index[63:56]
  input  logic [63:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_sprite_id[7:0], out_texture[15:8], screen_column[29:16], sprite_size[42:30],
  // start_column[55:43], end_column[69:56], start_row[77:70], end_row[86:78],
  // depth[109:87], zero fill[111:110]
  output logic [111:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [23:0]  cfg_data_i
);

  ssp_pkg::cam_t        cam_q;
  ssp_pkg::sprite_job_t job_push, job_pop;
  ssp_pkg::result_t     res;
  logic push, pop, q_ready, q_valid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_q.player_x <= 24'sh070000;
      cam_q.player_y <= 24'sh040000;
      cam_q.dir_x    <= 18'sh30000;
      cam_q.dir_y    <= '0;
      cam_q.plane_x  <= '0;
      cam_q.plane_y  <= 18'sh15555;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ssp_pkg::CFG_PLAYER_X: cam_q.player_x <= cfg_data_i;
        ssp_pkg::CFG_PLAYER_Y: cam_q.player_y <= cfg_data_i;
        ssp_pkg::CFG_DIR_X:    cam_q.dir_x    <= cfg_data_i[17:0];
        ssp_pkg::CFG_DIR_Y:    cam_q.dir_y    <= cfg_data_i[17:0];
        ssp_pkg::CFG_PLANE_X:  cam_q.plane_x  <= cfg_data_i[17:0];
        ssp_pkg::CFG_PLANE_Y:  cam_q.plane_y  <= cfg_data_i[17:0];
        default: ;
      endcase
    end
  end

  ssp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cam_i         (cam_q),
    .valid_i       (s_axis_tvalid),
    .ready_o       (s_axis_tready),
    .id_i          (s_axis_tdata[7:0]),
    .x_i           (s_axis_tdata[31:8]),
    .y_i           (s_axis_tdata[55:32]),
    .tex_i         (s_axis_tdata[63:56]),
    .push_o        (push),
    .queue_ready_i (q_ready),
    .job_o         (job_push)
  );

  ssp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_push),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (job_pop)
  );

  ssp_back #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (job_pop),
    .pop_o       (pop),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .result_o    (res)
  );

  assign m_axis_tdata = {2'b00, res.depth, res.end_row, res.start_row, res.end_column,
                         res.start_column, res.sprite_size, res.screen_column,
                         res.texture, res.sprite_id};

endmodule

@@ dv/tb_sprite_screen_projection.sv @@
module tb_sprite_screen_projection;
  import ssp_pkg::*;

  localparam int SCR_W = 640;
  localparam int SCR_H = 480;

  typedef struct packed {
    logic [7:0]  id;
    logic [23:0] sx;
    logic [23:0] sy;
    logic [7:0]  tex;
  } sprite_word_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [111:0] m_axis_tdata;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i;
  logic [23:0]  cfg_data_i;

  sprite_screen_projection dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Camera copy held by the projection predictor.
  longint cam_px, cam_py, cam_dx, cam_dy, cam_lx, cam_ly;
  result_t projected_q[$];
  int  fail_cnt;
  bit  hold_off;
  int  stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic longint sx_val(logic [23:0] v, int w);
    longint r;
    r = v & ((64'd1 << w) - 1);
    if (r[w-1]) r = r - (64'sd1 <<< w);
    return r;
  endfunction

  function automatic longint magn(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic void project_sprite(sprite_word_t w);
    longint rx, ry, dot, det, txn, tyn, num, den, col, sz, half, dq;
    longint scol, ecol, srow, erow;
    result_t r;
    rx = sx_val(w.sx, 24) - cam_px;
    ry = sx_val(w.sy, 24) - cam_py;
    dot = rx * cam_dx + ry * cam_dy;
    if (dot < 0) return;
    det = cam_lx * cam_dy - cam_dx * cam_ly;
    if (det == 0) return;
    txn = cam_dy * rx - cam_dx * ry;
    tyn = cam_lx * ry - cam_ly * rx;
    if (tyn == 0 || ((tyn < 0) != (det < 0))) return;
    dq = (magn(tyn) <<< 16) / magn(det);
    if (dq == 0) return;
    if (dq > 8388607) dq = 8388607;
    num = (tyn + txn) * SCR_W;
    den = 2 * tyn;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    col = num / den;
    if (col < -8192) col = -8192;
    if (col > 8191) col = 8191;
    sz = (SCR_H * magn(det)) / magn(tyn);
    if (sz > 8191) sz = 8191;
    half = sz / 2;
    scol = col - half;
    if (scol < 0) scol = 0;
    ecol = col + half;
    if (ecol > SCR_W - 1) ecol = SCR_W - 1;
    srow = SCR_H / 2 - half;
    if (srow < 0) srow = 0;
    erow = SCR_H / 2 + half;
    if (erow > SCR_H - 1) erow = SCR_H - 1;
    r.sprite_id     = w.id;
    r.texture       = w.tex;
    r.screen_column = col[13:0];
    r.sprite_size   = sz[12:0];
    r.start_column  = scol[12:0];
    r.end_column    = ecol[13:0];
    r.start_row     = srow[7:0];
    r.end_row       = erow[8:0];
    r.depth         = dq[22:0];
    projected_q.push_back(r);
  endfunction

  // Result checker and receiver stall pattern.
  always @(posedge clk_i) begin
    result_t e;
    logic [111:0] d;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      d = m_axis_tdata;
      if (projected_q.size() == 0) begin
        $error("unexpected result word %h", d);
        fail_cnt++;
      end else begin
        e = projected_q.pop_front();
        if (d[7:0] != e.sprite_id) begin
          $error("out_sprite_id exp %0d got %0d", e.sprite_id, d[7:0]); fail_cnt++;
        end
        if (d[15:8] != e.texture) begin
          $error("out_texture exp %0d got %0d", e.texture, d[15:8]); fail_cnt++;
        end
        if (d[29:16] != e.screen_column) begin
          $error("screen_column exp %0d got %0d", $signed(e.screen_column),
                 $signed(d[29:16])); fail_cnt++;
        end
        if (d[42:30] != e.sprite_size) begin
          $error("sprite_size exp %0d got %0d", e.sprite_size, d[42:30]); fail_cnt++;
        end
        if (d[55:43] != e.start_column) begin
          $error("start_column exp %0d got %0d", e.start_column, d[55:43]); fail_cnt++;
        end
        if (d[69:56] != e.end_column) begin
          $error("end_column exp %0d got %0d", $signed(e.end_column),
                 $signed(d[69:56])); fail_cnt++;
        end
        if (d[77:70] != e.start_row) begin
          $error("start_row exp %0d got %0d", e.start_row, d[77:70]); fail_cnt++;
        end
        if (d[86:78] != e.end_row) begin
          $error("end_row exp %0d got %0d", e.end_row, d[86:78]); fail_cnt++;
        end
        if (d[109:87] != e.depth) begin
          $error("depth exp %0d got %0d", e.depth, d[109:87]); fail_cnt++;
        end
      end
    end
    if (hold_off) m_axis_tready <= 1'b0;
    else          m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Sprites are predicted when the word is taken, so accepted order is kept.
  // Valid stays high after the word is taken; whoever waits next drops it.
  task automatic send_sprite(sprite_word_t w);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {w.tex, w.sy, w.sx, w.id};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    project_sprite(w);
  endtask

  task automatic idle_gap();
    if ($urandom_range(7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    int n;
    n = 0;
    s_axis_tvalid <= 1'b0;
    while (projected_q.size() != 0) @(posedge clk_i);
    // Hidden sprites may still be in flight behind the last visible one.
    while (n < 40) begin
      @(posedge clk_i);
      n++;
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [23:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_PLAYER_X: cam_px = sx_val(val, 24);
      CFG_PLAYER_Y: cam_py = sx_val(val, 24);
      CFG_DIR_X:    cam_dx = sx_val(val, 18);
      CFG_DIR_Y:    cam_dy = sx_val(val, 18);
      CFG_PLANE_X:  cam_lx = sx_val(val, 18);
      CFG_PLANE_Y:  cam_ly = sx_val(val, 18);
      default: ;
    endcase
  endtask

  task automatic set_camera(longint px, longint py, longint dx, longint dy,
                            longint lx, longint ly);
    drain();
    write_reg(CFG_PLAYER_X, px[23:0]);
    write_reg(CFG_PLAYER_Y, py[23:0]);
    write_reg(CFG_DIR_X, dx[23:0]);
    write_reg(CFG_DIR_Y, dy[23:0]);
    write_reg(CFG_PLANE_X, lx[23:0]);
    write_reg(CFG_PLANE_Y, ly[23:0]);
  endtask

  function automatic sprite_word_t mk(longint x, longint y);
    sprite_word_t w;
    w.id  = $urandom;
    w.tex = $urandom;
    w.sx  = x[23:0];
    w.sy  = y[23:0];
    return w;
  endfunction

  // Random sprite, mostly near the viewer so that many are visible.
  function automatic sprite_word_t rand_sprite();
    case ($urandom_range(3))
      0: return mk($signed($urandom), $signed($urandom));
      1: return mk(cam_px + $signed($urandom_range(0, 1 << 20)) - (1 << 19),
                   cam_py + $signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return mk(cam_px + ((cam_dx * $urandom_range(1, 2000000)) >>> 16)
                         + $signed($urandom_range(0, 1 << 18)) - (1 << 17),
                         cam_py + ((cam_dy * $urandom_range(1, 2000000)) >>> 16)
                         + $signed($urandom_range(0, 1 << 18)) - (1 << 17));
    endcase
  endfunction

  task automatic test_directed();
    sprite_word_t w;
    send_sprite(mk(0, 262144));
    send_sprite(mk(458752, 262144));
    send_sprite(mk(458752 + 65536, 262144));
    send_sprite(mk(458752 - 1, 262144));
    send_sprite(mk(458752 - 200, 262144));
    send_sprite(mk(0, 0));
    send_sprite(mk(-8388608, -8388608));
    send_sprite(mk(-8388608, 8388607));
    send_sprite(mk(8388607, 8388607));
    send_sprite(mk(-8388608, 262144 + 8000000));
    send_sprite(mk(458752 - 300, 262144 - 8000000));
    w = mk(458752 - 65536, 262144);
    w.id = 8'hff; w.tex = 8'h00;
    send_sprite(w);
    w.id = 8'h00; w.tex = 8'hff;
    send_sprite(w);
    // Degenerate camera: plane parallel to direction.
    set_camera(0, 0, 65536, 0, 65536, 0);
    send_sprite(mk(65536, 0));
    // Extreme camera values.
    set_camera(-8388608, 8388607, -131072, 131071, 131071, -131072);
    send_sprite(mk(-8388608 - 65536, 8388607));
    send_sprite(mk(-8000000, 8000000));
    send_sprite(mk(8388607, -8388608));
    set_camera(8388607, -8388608, 1, -1, -1, -1);
    send_sprite(mk(8388607 - 100, -8388608));
    send_sprite(mk(0, 0));
  endtask

  task automatic test_random(int n);
    int burst;
    int i;
    i = 0;
    while (i < n) begin
      burst = $urandom_range(1, 30);
      repeat (burst) begin
        send_sprite(rand_sprite());
        if ($urandom_range(3) == 0) idle_gap();
        i++;
      end
      if ($urandom_range(1) == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      repeat (100) send_sprite(mk(cam_px + ((cam_dx * $urandom_range(1, 300000)) >>> 16),
                                  cam_py + ((cam_dy * $urandom_range(1, 300000)) >>> 16)));
    join
    drain();
  endtask

  task automatic random_camera(int k);
    longint ang;
    case (k % 4)
      0: set_camera(458752, 262144, -65536, 0, 0, 87381);
      1: set_camera(0, 0, 0, 65536, 87381, 0);
      2: set_camera($signed($urandom_range(0, 1 << 22)) - (1 << 21),
                    $signed($urandom_range(0, 1 << 22)) - (1 << 21),
                    $signed($urandom_range(0, 262143)) - 131072,
                    $signed($urandom_range(0, 262143)) - 131072,
                    $signed($urandom_range(0, 262143)) - 131072,
                    $signed($urandom_range(0, 262143)) - 131072);
      default: begin
        ang = $urandom_range(0, 65536);
        set_camera($signed($urandom), $signed($urandom), ang, 65536 - ang,
                   -(65536 - ang), ang);
      end
    endcase
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_PLAYER_X;
    cfg_data_i = '0;
    fail_cnt = 0;
    hold_off = 1'b0;
    stall_pct = 30;
    cam_px = 458752; cam_py = 262144; cam_dx = -65536;
    cam_dy = 0; cam_lx = 0; cam_ly = 87381;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    set_camera(458752, 262144, -65536, 0, 0, 87381);
    test_backpressure();
    for (int k = 0; k < 8; k++) begin
      if (k != 0) random_camera(k);
      stall_pct = (k % 3 == 0) ? 0 : $urandom_range(10, 70);
      test_random(200);
    end
    stall_pct = 20;
    drain();
    if (fail_cnt == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/ssp_pkg.sv
rtl/core/ssp_front.sv
rtl/core/ssp_fifo.sv
rtl/core/ssp_back.sv
rtl/core/sprite_screen_projection.sv
dv/tb_sprite_screen_projection.sv
